// ===== rtl/core/clns_pkg.sv =====
`timescale 1ns / 1ps

package clns_pkg;

  localparam int unsigned PcW = 6;

  // Entry points of the microprogram, one per operation.
  localparam logic [PcW-1:0] EntryChar   = 6'd0;
  localparam logic [PcW-1:0] EntryCursor = 6'd2;
  localparam logic [PcW-1:0] EntryBcd    = 6'd4;
  localparam logic [PcW-1:0] EntryInit   = 6'd8;

  // Operation codes carried on the input selector.
  localparam logic [1:0] ModeChar   = 2'd0;
  localparam logic [1:0] ModeCursor = 2'd1;
  localparam logic [1:0] ModeBcd    = 2'd2;
  localparam logic [1:0] ModeInit   = 2'd3;

  typedef enum logic [1:0] {
    NibConst  = 2'd0,
    NibByteHi = 2'd1,
    NibByteLo = 2'd2
  } nib_sel_e;

  typedef struct packed {
    logic        strobe;
    logic        rs;
    logic        rw;
    nib_sel_e    sel;
    logic [3:0]  nib;
    logic [15:0] settle;
    logic        last;
  } ucode_t;

  function automatic ucode_t mk(input logic strobe, input logic rs, input logic rw,
                                input nib_sel_e sel, input logic [3:0] nib,
                                input logic [15:0] settle, input logic last);
    ucode_t w;
    w.strobe = strobe;
    w.rs     = rs;
    w.rw     = rw;
    w.sel    = sel;
    w.nib    = nib;
    w.settle = settle;
    w.last   = last;
    return w;
  endfunction

  // Microprogram. A command byte goes out high nibble first; the high half
  // always settles 10 us, the low half carries the wait of that command.
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      6'd0:  w = mk(1'b1, 1'b1, 1'b0, NibByteHi, 4'h0, 16'd10,    1'b0);
      6'd1:  w = mk(1'b1, 1'b1, 1'b0, NibByteLo, 4'h0, 16'd0,     1'b1);
      6'd2:  w = mk(1'b1, 1'b0, 1'b0, NibByteHi, 4'h0, 16'd10,    1'b0);
      6'd3:  w = mk(1'b1, 1'b0, 1'b0, NibByteLo, 4'h0, 16'd0,     1'b1);
      6'd4:  w = mk(1'b1, 1'b1, 1'b0, NibConst,  4'h3, 16'd10,    1'b0);
      6'd5:  w = mk(1'b1, 1'b1, 1'b0, NibByteHi, 4'h0, 16'd0,     1'b0);
      6'd6:  w = mk(1'b1, 1'b1, 1'b0, NibConst,  4'h3, 16'd10,    1'b0);
      6'd7:  w = mk(1'b1, 1'b1, 1'b0, NibByteLo, 4'h0, 16'd0,     1'b1);
      6'd8:  w = mk(1'b0, 1'b1, 1'b1, NibConst,  4'h0, 16'd50000, 1'b0);
      6'd9:  w = mk(1'b0, 1'b0, 1'b0, NibConst,  4'h0, 16'd50000, 1'b0);
      6'd10: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h3, 16'd10000, 1'b0);
      6'd11: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h3, 16'd150,   1'b0);
      6'd12: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h3, 16'd50,    1'b0);
      6'd13: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h2, 16'd50,    1'b0);
      6'd14: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h2, 16'd10,    1'b0);
      6'd15: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'hD, 16'd50,    1'b0);
      6'd16: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h1, 16'd10,    1'b0);
      6'd17: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h7, 16'd50,    1'b0);
      6'd18: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h7, 16'd10,    1'b0);
      6'd19: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h0, 16'd50,    1'b0);
      6'd20: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h5, 16'd10,    1'b0);
      6'd21: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'hD, 16'd50,    1'b0);
      6'd22: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h6, 16'd10,    1'b0);
      6'd23: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'hE, 16'd50,    1'b0);
      6'd24: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h0, 16'd10,    1'b0);
      6'd25: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'hC, 16'd50000, 1'b0);
      6'd26: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h0, 16'd10,    1'b0);
      6'd27: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h1, 16'd5000,  1'b0);
      6'd28: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h0, 16'd10,    1'b0);
      6'd29: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h6, 16'd50000, 1'b0);
      6'd30: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h2, 16'd10,    1'b0);
      6'd31: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h9, 16'd50,    1'b0);
      6'd32: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h0, 16'd10,    1'b0);
      6'd33: w = mk(1'b1, 1'b0, 1'b0, NibConst,  4'h1, 16'd2000,  1'b1);
      default: w = mk(1'b0, 1'b0, 1'b0, NibConst, 4'h0, 16'd0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/clns_decode.sv =====
`timescale 1ns / 1ps

module clns_decode (
  input  logic [1:0]          mode_i,
  input  logic [7:0]          value_i,
  input  logic [2:0]          row_i,
  input  logic [4:0]          column_i,
  output logic [7:0]          byte_o,
  output logic [clns_pkg::PcW-1:0] entry_o
);
  import clns_pkg::*;

  logic [7:0] mapped;
  logic [2:0] row_m1;
  logic [4:0] col_m1;

  // Latin-1 umlauts to the display's character codes.
  always_comb begin
    case (value_i)
      8'hE4:   mapped = 8'h84;
      8'hC4:   mapped = 8'h8E;
      8'hF6:   mapped = 8'h94;
      8'hD6:   mapped = 8'h99;
      8'hFC:   mapped = 8'h81;
      8'hDC:   mapped = 8'h9A;
      default: mapped = value_i;
    endcase
  end

  assign row_m1 = row_i - 3'd1;
  assign col_m1 = column_i - 5'd1;

  // The BCD program supplies the ASCII high nibble itself, so it takes the
  // raw packed byte.
  always_comb begin
    case (mode_i)
      ModeChar: begin
        byte_o  = mapped;
        entry_o = EntryChar;
      end
      ModeCursor: begin
        byte_o  = {1'b1, row_m1, col_m1[3:0]};
        entry_o = EntryCursor;
      end
      ModeBcd: begin
        byte_o  = value_i;
        entry_o = EntryBcd;
      end
      default: begin
        byte_o  = value_i;
        entry_o = EntryInit;
      end
    endcase
  end

endmodule

// ===== rtl/core/char_lcd_nibble_sequencer.sv =====
`timescale 1ns / 1ps

// Character display nibble sequencer for a 4-bit parallel LCD bus.
//
// The input channel takes one operation per beat: a data character (with
// umlaut mapping), a cursor move, a packed BCD byte shown as two digits,
// or the power-up command sequence. Each operation expands into a run of
// transfer steps on the output channel, one step per beat, tlast marking
// the final step of the run.
//
// Sequencing: an accepted operation starts a run, and each step is read from
// the program table and presented from the output register; the steps follow
// one per cycle while the receiver keeps up: 2 steps for a character or
// cursor move, 4 for a BCD byte and 26 for the init sequence, set by the
// microprogram counter that reads one control word per cycle from the
// program table. The input is ready again only once the last step sits in
// the output register, so no new operation is taken while a run is going.
//
// Reset clears the sequencer and the output valid. When the receiver stalls,
// the output register holds its step and the program counter waits, so no
// step is lost or repeated; the input stays blocked until the run ends.
module char_lcd_nibble_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // value[7:0], row[10:8], column[15:11]
  input  logic [1:0]  s_axis_tuser_i,   // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // reg_select[0], read_write[1], nibble[5:2],
                                        // settle_us[21:6], zero[23:22]
  output logic        m_axis_tuser_o,   // strobe_res[0]
  output logic        m_axis_tlast_o    // last
);
  import clns_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic           state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [7:0]     byte_q, byte_d;
  logic           m_valid_q, m_valid_d;
  logic           strobe_q, rs_q, rw_q, last_q;
  logic [3:0]     nib_q;
  logic [15:0]    settle_q;

  logic [7:0]     dec_byte;
  logic [PcW-1:0] dec_entry;
  logic           accept;
  logic           issue;
  ucode_t         uw;
  logic [3:0]     nib_sel;

  clns_decode u_decode (
    .mode_i   (s_axis_tuser_i),
    .value_i  (s_axis_tdata_i[7:0]),
    .row_i    (s_axis_tdata_i[10:8]),
    .column_i (s_axis_tdata_i[15:11]),
    .byte_o   (dec_byte),
    .entry_o  (dec_entry)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // During a run, a step leaves the program whenever the output register is free or being read.
  assign issue = (state_q == ST_RUN) && (!m_valid_q || m_axis_tready_i);
  assign uw    = ucode_rom(pc_q);

  always_comb begin
    case (uw.sel)
      NibByteHi: nib_sel = byte_q[7:4];
      NibByteLo: nib_sel = byte_q[3:0];
      default:   nib_sel = uw.nib;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    byte_d    = byte_q;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if (accept) begin
      state_d = ST_RUN;
      pc_d    = dec_entry;
      byte_d  = dec_byte;
    end else if (issue) begin
      m_valid_d = 1'b1;
      pc_d      = pc_q + PcW'(1);
      if (uw.last) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (issue) begin
      strobe_q <= uw.strobe;
      rs_q     <= uw.rs;
      rw_q     <= uw.rw;
      nib_q    <= nib_sel;
      settle_q <= uw.settle;
      last_q   <= uw.last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, settle_q, nib_q, rw_q, rs_q};
  assign m_axis_tuser_o  = strobe_q;
  assign m_axis_tlast_o  = last_q;

  // An accepted operation starts its run at the entry point of its mode.
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (pc_q == $past(dec_entry)) && (state_q == ST_RUN))
    else $error("run did not start at the operation entry point");

  // Issuing the final control word of a run returns the sequencer to idle.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && uw.last) |=> (state_q == ST_IDLE) && m_valid_q && m_axis_tlast_o)
    else $error("run did not end on its last step");

  // A new step only appears while a run is in progress.
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_RUN))
    else $error("output step raised outside a run");

endmodule

// ===== test/lcd_step_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the nibble sequencer, expands every accepted
// operation into the transfer steps it must produce and compares each
// output beat with the oldest step still due.
module lcd_step_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,    // value[7:0], row[10:8], column[15:11]
  input  logic [1:0]  s_tuser_i,    // mode[1:0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,    // reg_select[0], read_write[1], nibble[5:2],
                                    // settle_us[21:6], zero[23:22]
  input  logic        m_tuser_i,    // strobe_res[0]
  input  logic        m_tlast_i,
  output logic [31:0] outstanding_o,
  output logic [31:0] fail_count_o,
  output logic [31:0] steps_checked_o
);
  import clns_pkg::*;

  typedef struct packed {
    logic        strobe;
    logic        rs;
    logic        rw;
    logic [3:0]  nib;
    logic [15:0] settle;
    logic        last;
  } lcd_step_t;

  lcd_step_t steps_due[$];
  int        mismatches;
  int        steps_checked;

  // Latin-1 umlauts land on the display's own glyph codes.
  function automatic logic [7:0] display_code(input logic [7:0] latin1);
    case (latin1)
      8'hE4:   return 8'h84;
      8'hC4:   return 8'h8E;
      8'hF6:   return 8'h94;
      8'hD6:   return 8'h99;
      8'hFC:   return 8'h81;
      8'hDC:   return 8'h9A;
      default: return latin1;
    endcase
  endfunction

  function automatic logic [7:0] power_up_cmd(input int idx);
    case (idx)
      0: return 8'h2D;
      1: return 8'h17;
      2: return 8'h70;
      3: return 8'h5D;
      4: return 8'h6E;
      5: return 8'h0C;
      6: return 8'h01;
      7: return 8'h06;
      8: return 8'h29;
      default: return 8'h01;
    endcase
  endfunction

  function automatic logic [15:0] power_up_wait(input int idx);
    case (idx)
      5: return 16'd50000;
      6: return 16'd5000;
      7: return 16'd50000;
      9: return 16'd2000;
      default: return 16'd50;
    endcase
  endfunction

  function automatic logic [15:0] wake_wait(input int idx);
    case (idx)
      0: return 16'd10000;
      1: return 16'd150;
      default: return 16'd50;
    endcase
  endfunction

  task automatic push_step(input logic strobe, input logic rs, input logic rw,
                           input logic [3:0] nib, input logic [15:0] settle);
    lcd_step_t s;
    s.strobe = strobe;
    s.rs     = rs;
    s.rw     = rw;
    s.nib    = nib;
    s.settle = settle;
    s.last   = 1'b0;
    steps_due.push_back(s);
  endtask

  // High nibble first; it always settles 10 us, the low nibble carries the
  // wait that belongs to the byte.
  task automatic push_byte(input logic rs, input logic [7:0] byte_val,
                           input logic [15:0] tail);
    push_step(1'b1, rs, 1'b0, byte_val[7:4], 16'd10);
    push_step(1'b1, rs, 1'b0, byte_val[3:0], tail);
  endtask

  task automatic expand_op(input logic [1:0] mode, input logic [7:0] value,
                           input logic [2:0] row, input logic [4:0] column);
    lcd_step_t tail_step;
    logic [7:0] cmd;
    case (mode)
      ModeChar: begin
        push_byte(1'b1, display_code(value), 16'd0);
      end
      ModeCursor: begin
        // Row and column are one-based and simply wrap when out of range.
        cmd = {1'b1, row - 3'd1, column[3:0] - 4'd1};
        push_byte(1'b0, cmd, 16'd0);
      end
      ModeBcd: begin
        push_byte(1'b1, display_code({4'd0, value[7:4]} + 8'd48), 16'd0);
        push_byte(1'b1, display_code({4'd0, value[3:0]} + 8'd48), 16'd0);
      end
      default: begin
        push_step(1'b0, 1'b1, 1'b1, 4'h0, 16'd50000);
        push_step(1'b0, 1'b0, 1'b0, 4'h0, 16'd50000);
        for (int i = 0; i < 4; i++)
          push_step(1'b1, 1'b0, 1'b0, (i == 3) ? 4'h2 : 4'h3, wake_wait(i));
        for (int i = 0; i < 10; i++)
          push_byte(1'b0, power_up_cmd(i), power_up_wait(i));
      end
    endcase
    tail_step = steps_due.pop_back();
    tail_step.last = 1'b1;
    steps_due.push_back(tail_step);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_step();
    lcd_step_t want;
    lcd_step_t got;
    string     want_s;
    string     got_s;
    got.strobe = m_tuser_i;
    got.rs     = m_tdata_i[0];
    got.rw     = m_tdata_i[1];
    got.nib    = m_tdata_i[5:2];
    got.settle = m_tdata_i[21:6];
    got.last   = m_tlast_i;
    if (steps_due.size() == 0) begin
      report_mismatch($sformatf("output beat with no step due (tdata=%h)", m_tdata_i));
      return;
    end
    want = steps_due.pop_front();
    steps_checked++;
    if (got != want || m_tdata_i[23:22] != 2'b00) begin
      want_s = $sformatf("strobe=%0b rs=%0b rw=%0b nib=%h settle=%0d last=%0b",
                         want.strobe, want.rs, want.rw, want.nib, want.settle, want.last);
      got_s  = $sformatf("strobe=%0b rs=%0b rw=%0b nib=%h settle=%0d last=%0b",
                         got.strobe, got.rs, got.rw, got.nib, got.settle, got.last);
      report_mismatch($sformatf("step %0d: want %s, got %s pad=%b",
                                steps_checked, want_s, got_s, m_tdata_i[23:22]));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_due.delete();
      mismatches      = 0;
      steps_checked   = 0;
      outstanding_o   <= '0;
      fail_count_o    <= '0;
      steps_checked_o <= '0;
    end else begin
      if (s_tvalid_i && s_tready_i)
        expand_op(s_tuser_i, s_tdata_i[7:0], s_tdata_i[10:8], s_tdata_i[15:11]);
      if (m_tvalid_i && m_tready_i)
        check_step();
      outstanding_o   <= steps_due.size();
      fail_count_o    <= mismatches;
      steps_checked_o <= steps_checked;
    end
  end

endmodule

// ===== test/char_lcd_nibble_sequencer_tb.sv =====
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_tb;
  import clns_pkg::*;

  localparam int RandomPerPhase = 140;
  localparam int HoldCycles     = 200;
  localparam int IdleLimit      = 2000;
  localparam int TailCycles     = 40;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;   // value[7:0], row[10:8], column[15:11]
  logic [1:0]  s_axis_tuser_i  = ModeChar;   // mode[1:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;         // reg_select[0], read_write[1], nibble[5:2],
                                       // settle_us[21:6], zero[23:22]
  logic        m_axis_tuser_o;         // strobe_res[0]
  logic        m_axis_tlast_o;

  logic [31:0] outstanding;
  logic [31:0] fail_count;
  logic [31:0] steps_checked;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int hold_left   = 0;
  int quiet_cycles = 0;
  int ops_sent [4] = '{0, 0, 0, 0};

  char_lcd_nibble_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  lcd_step_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid_i),
    .s_tready_i      (s_axis_tready_o),
    .s_tdata_i       (s_axis_tdata_i),
    .s_tuser_i       (s_axis_tuser_i),
    .m_tvalid_i      (m_axis_tvalid_o),
    .m_tready_i      (m_axis_tready_i),
    .m_tdata_i       (m_axis_tdata_o),
    .m_tuser_i       (m_axis_tuser_o),
    .m_tlast_i       (m_axis_tlast_o),
    .outstanding_o   (outstanding),
    .fail_count_o    (fail_count),
    .steps_checked_o (steps_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver side. A requested hold-off is counted here, so the sender can
  // keep offering operations while the block backs up and stalls its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready_i <= 1'b0;
      hold_left = HoldCycles - 1;
      hold_done = 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: a long run of cycles with no beat on either side means the
  // block has hung.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles == IdleLimit) begin
      $display("Timeout: no beat for %0d cycles, %0d steps still due",
               IdleLimit, outstanding);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] latin1_umlaut(input int idx);
    case (idx)
      0: return 8'hE4;
      1: return 8'hC4;
      2: return 8'hF6;
      3: return 8'hD6;
      4: return 8'hFC;
      default: return 8'hDC;
    endcase
  endfunction

  // Offers one operation, idling first at the current rate. Valid is left
  // high after the beat so back-to-back operations need no extra cycle.
  task automatic send_op(input logic [1:0] mode, input logic [7:0] value,
                         input logic [2:0] row, input logic [4:0] column);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 16'($urandom);
      s_axis_tuser_i  <= 2'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {column, row, value};
    s_axis_tuser_i  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    ops_sent[mode]++;
  endtask

  // Mostly characters, cursor moves and BCD bytes with in-range fields;
  // the long power-up sequence and wild row or column values now and then.
  task automatic send_random_op();
    logic [1:0] mode;
    logic [7:0] value;
    logic [2:0] row;
    logic [4:0] column;
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)      mode = ModeChar;
    else if (pick < 65) mode = ModeCursor;
    else if (pick < 94) mode = ModeBcd;
    else                mode = ModeInit;
    value = 8'($urandom);
    if (mode == ModeChar && $urandom_range(3) == 0)
      value = latin1_umlaut($urandom_range(5));
    if (mode == ModeBcd && $urandom_range(3) != 0) begin
      value[7:4] = 4'($urandom_range(9));
      value[3:0] = 4'($urandom_range(9));
    end
    row    = 3'($urandom_range(4, 1));
    column = 5'($urandom_range(16, 1));
    if ($urandom_range(9) == 0) begin
      row    = 3'($urandom);
      column = 5'($urandom);
    end
    send_op(mode, value, row, column);
  endtask

  // Sender pause: drop valid and wait until every step due has come out.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 26;
    rx_idle_pct <= 59;

    // Character extremes, every umlaut and one plain letter carrying noise in
    // the ignored row and column fields.
    send_op(ModeChar, 8'h00, 3'd0, 5'd0);
    send_op(ModeChar, 8'hFF, 3'd7, 5'd31);
    for (int i = 0; i < 6; i++)
      send_op(ModeChar, latin1_umlaut(i), 3'd1, 5'd1);
    send_op(ModeChar, 8'h41, 3'd5, 5'd17);
    // Cursor corners, then zero and maximal fields that wrap.
    send_op(ModeCursor, 8'hFF, 3'd1, 5'd1);
    send_op(ModeCursor, 8'h00, 3'd4, 5'd16);
    send_op(ModeCursor, 8'h5A, 3'd0, 5'd0);
    send_op(ModeCursor, 8'hA5, 3'd7, 5'd31);
    // BCD: both digit extremes and nibbles above nine.
    send_op(ModeBcd, 8'h00, 3'd7, 5'd31);
    send_op(ModeBcd, 8'h99, 3'd0, 5'd0);
    send_op(ModeBcd, 8'hFF, 3'd2, 5'd9);
    send_op(ModeBcd, 8'hA5, 3'd3, 5'd4);
    // Power-up sequence, once from idle and once right behind a character.
    send_op(ModeInit, 8'hFF, 3'd7, 5'd31);
    send_op(ModeChar, 8'h7E, 3'd2, 5'd2);
    send_op(ModeInit, 8'h00, 3'd0, 5'd0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct <= 59;
        end
        1: begin
          tx_idle_pct = 59;
          rx_idle_pct <= 26;
        end
        default: begin
          // Free-running sender against a receiver that first holds off for
          // a long stretch, then takes every beat.
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
          hold_req    <= 1'b1;
        end
      endcase
      for (int n = 0; n < RandomPerPhase; n++)
        send_random_op();
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d character, %0d cursor, %0d BCD and %0d power-up operations",
             ops_sent[ModeChar], ops_sent[ModeCursor], ops_sent[ModeBcd],
             ops_sent[ModeInit]);
    $display("Checked %0d transfer steps under three stall mixes and a %0d-cycle hold-off",
             steps_checked, HoldCycles);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d steps never seen", fail_count, outstanding);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
